// File: rtl/core/gwc_pkg.sv
// Shared types, codes and helpers for the grid wall carve / set merge block.
// Used by the top level, gwc_scan, the checker and the bench; no dependencies.
package gwc_pkg;

	localparam int LABEL_W = 10;
	localparam int WORD_W  = LABEL_W + 2;
	localparam int SIZE_W  = 6;
	localparam int COORD_W = 5;

	// cell word layout: {up_open, right_open, label}
	localparam int UP_BIT    = LABEL_W + 1;
	localparam int RIGHT_BIT = LABEL_W;

	localparam logic [1:0] STATUS_CARVED  = 2'd0;
	localparam logic [1:0] STATUS_SAME    = 2'd1;
	localparam logic [1:0] STATUS_BORDER  = 2'd2;
	localparam logic [1:0] STATUS_READ    = 2'd3;

	localparam logic REQ_CARVE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	localparam logic DIR_UP    = 1'b0;
	localparam logic DIR_RIGHT = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_DEFAULT = 6'd20;
	localparam logic [SIZE_W-1:0] SIZE_MIN     = 6'd4;

	typedef struct packed {
		logic run;
		logic last;
	} scan_ctl_t;

	// Small values fall back to the default, large ones clamp to the grid limit.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
			input int limit);
		logic [SIZE_W-1:0] v;
		v = (raw < SIZE_MIN) ? SIZE_DEFAULT : raw;
		return (int'(v) > limit) ? SIZE_W'(limit) : v;
	endfunction

endpackage

// File: rtl/core/grid_wall_carve_set_merge.sv
// Grid wall carver with set merging. Every cell keeps a 10-bit set label and the
// open state of the walls above it and to its right, in one RAM of MAX_ROWS*MAX_COLS
// words. After reset a clearing pass writes every word: it gives each cell its
// own index as label and closes all walls; no item is taken meanwhile, config
// writes are. One item is worked at a time. A request outside the grid goes
// straight to the result; a read or a border reject reads the cell, a same-set
// reject also reads the neighbour; a carve that merges two sets then sweeps
// every cell in use through the single RAM read port, one cell per cycle,
// relabelling the old set. Once a result is loaded into the output register the
// block returns to idle and takes the next item. A finished result waits in the
// output register while the next item is accepted; if it is still not taken when
// the next result is done, that result holds and the input stays closed.
// Depends on gwc_pkg, gwc_ram, gwc_scan.
module grid_wall_carve_set_merge import gwc_pkg::*; #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // row[4:0], col[9:5], direction[10], zero[15:11]
	input  logic              s_tuser,   // req_type[0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // up_open[0], right_open[1], set_label[11:2], zero
	output logic [1:0]        m_tuser,   // status[1:0]
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RCELL = 3'd2;
	localparam logic [2:0] ST_CELL  = 3'd3;
	localparam logic [2:0] ST_NB    = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [SIZE_W-1:0]   rows_q;
	logic [SIZE_W-1:0]   cols_q;
	logic [AW-1:0]       init_q;

	logic                req_q;
	logic [COORD_W-1:0]  row_q;
	logic [COORD_W-1:0]  col_q;
	logic                dir_q;
	logic [AW-1:0]       cell_q;
	logic [WORD_W-1:0]   cell_word_q;
	logic [LABEL_W-1:0]  new_label_q;

	logic [1:0]          res_status_q;
	logic [WORD_W-1:0]   res_word_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [WORD_W-1:0]   out_word_q;

	logic                valid_s1;
	logic                last_s1;
	logic [AW-1:0]       addr_s1;

	logic [COORD_W-1:0]  in_row;
	logic [COORD_W-1:0]  in_col;
	logic                in_dir;
	logic                in_accept;
	logic                outside;
	logic                border;
	logic [AW-1:0]       nb_addr;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	logic                scan_start;
	logic [AW-1:0]       scan_addr;
	scan_ctl_t           scan_ctl;

	logic                match;
	logic [WORD_W-1:0]   relabel_word;
	logic                load_out;

	assign in_row    = s_tdata[4:0];
	assign in_col    = s_tdata[9:5];
	assign in_dir    = s_tdata[10];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign outside = ({1'b0, in_row} >= rows_q) || ({1'b0, in_col} >= cols_q);
	assign border  = ((dir_q == DIR_UP) && (row_q == '0)) ||
		((dir_q == DIR_RIGHT) && (({1'b0, col_q} + SIZE_W'(1)) >= cols_q));
	assign nb_addr = (dir_q == DIR_RIGHT) ? cell_q + AW'(1) : cell_q - AW'(MAX_COLS);

	// Relabel stage: compare the word read last cycle with the old label.
	assign match = valid_s1 && (ram_rdata[LABEL_W-1:0] == cell_word_q[LABEL_W-1:0]);

	always_comb begin
		relabel_word = {ram_rdata[UP_BIT], ram_rdata[RIGHT_BIT], new_label_q};
		if (addr_s1 == cell_q) begin
			if (dir_q == DIR_RIGHT) begin
				relabel_word[RIGHT_BIT] = 1'b1;
			end else begin
				relabel_word[UP_BIT] = 1'b1;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = relabel_word;
		if (state_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = init_q;
			ram_wdata = {2'b00, LABEL_W'(init_q)};
		end else if (state_q == ST_SCAN) begin
			ram_we = match;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_CELL: ram_raddr = nb_addr;
			ST_SCAN: ram_raddr = scan_addr;
			default: ram_raddr = cell_q;
		endcase
	end

	assign scan_start = (state_q == ST_NB) &&
		(ram_rdata[LABEL_W-1:0] != cell_word_q[LABEL_W-1:0]);

	gwc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gwc_scan #(
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.rows   (rows_q),
		.cols   (cols_q),
		.addr   (scan_addr),
		.ctl    (scan_ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= eff_size(SIZE_DEFAULT, MAX_ROWS);
			cols_q <= eff_size(SIZE_DEFAULT, MAX_COLS);
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= eff_size(cfg_data, MAX_ROWS);
			end else begin
				cols_q <= eff_size(cfg_data, MAX_COLS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= scan_ctl.run;
			last_s1  <= scan_ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= scan_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= outside ? ST_DONE : ST_RCELL;
					end
				end
				ST_RCELL: state_q <= ST_CELL;
				ST_CELL: begin
					if (req_q == REQ_READ || border) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_NB;
					end
				end
				ST_NB:   state_q <= scan_start ? ST_SCAN : ST_DONE;
				ST_SCAN: begin
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// Datapath of the sequencer; payload only, no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					req_q        <= s_tuser;
					row_q        <= in_row;
					col_q        <= in_col;
					dir_q        <= in_dir;
					cell_q       <= AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);
					res_status_q <= STATUS_BORDER;
					res_word_q   <= '0;
				end
			end
			ST_CELL: begin
				cell_word_q <= ram_rdata;
				res_word_q  <= ram_rdata;
				if (req_q == REQ_READ) begin
					res_status_q <= STATUS_READ;
				end else begin
					res_status_q <= border ? STATUS_BORDER : STATUS_SAME;
				end
			end
			ST_NB: begin
				new_label_q <= ram_rdata[LABEL_W-1:0];
				if (scan_start) begin
					res_status_q <= STATUS_CARVED;
					res_word_q   <= {cell_word_q[UP_BIT] || (dir_q == DIR_UP),
						cell_word_q[RIGHT_BIT] || (dir_q == DIR_RIGHT),
						ram_rdata[LABEL_W-1:0]};
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the beat until taken.
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_word_q   <= res_word_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0000, out_word_q[LABEL_W-1:0], out_word_q[RIGHT_BIT],
		out_word_q[UP_BIT]};

endmodule

// File: rtl/core/gwc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gwc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/gwc_scan.sv
// Address walker for the relabel sweep: visits every cell of the grid in use,
// one per cycle, row by row. Depends on gwc_pkg.
module gwc_scan import gwc_pkg::*; #(
	parameter int MAX_COLS = 32,
	parameter int AW       = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SIZE_W-1:0] rows,
	input  logic [SIZE_W-1:0] cols,
	output logic [AW-1:0]     addr,
	output scan_ctl_t         ctl
);

	logic [SIZE_W-1:0] r_q;
	logic [SIZE_W-1:0] c_q;
	logic [AW-1:0]     base_q;
	logic              run_q;
	logic              col_end;
	logic              row_end;

	assign col_end  = (c_q == cols - SIZE_W'(1));
	assign row_end  = (r_q == rows - SIZE_W'(1));
	assign addr     = base_q + AW'(c_q);
	assign ctl.run  = run_q;
	assign ctl.last = run_q && col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			r_q    <= '0;
			c_q    <= '0;
			base_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			r_q    <= '0;
			c_q    <= '0;
			base_q <= '0;
		end else if (run_q) begin
			if (col_end) begin
				c_q    <= '0;
				r_q    <= r_q + SIZE_W'(1);
				base_q <= base_q + AW'(MAX_COLS);
				if (row_end) begin
					run_q <= 1'b0;
				end
			end else begin
				c_q <= c_q + SIZE_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/gwc_chk.sv
// Port-level checker for the grid wall carve / set merge block, bound to its top level.
// Depends on gwc_pkg.
module gwc_chk import gwc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Every result needs an accepted item still pending.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result without pending item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items in flight");

	// Work one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("second item taken while busy");

	// A carve always leaves some wall of the cell open.
	a_carve_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_CARVED |-> m_tdata[0] || m_tdata[1])
		else $error("carve reported with both walls closed");

endmodule

bind grid_wall_carve_set_merge gwc_chk u_gwc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: test/tb.sv
// Self-checking bench for grid_wall_carve_set_merge: drives carve and read beats,
// predicts walls and set labels per cell, and checks every result beat in order.
// Depends on gwc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import gwc_pkg::*;

	localparam int MAX_R      = 32;
	localparam int MAX_C      = 32;
	localparam int CELLS      = MAX_R * MAX_C;
	localparam int STALL_MAX  = 20000;
	localparam int N_PHASES   = 8;

	typedef struct packed {
		logic             req;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic             dir;
	} grid_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               up;
		logic               right;
		logic [LABEL_W-1:0] label;
	} grid_resp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;

	grid_wall_carve_set_merge #(.MAX_ROWS(MAX_R), .MAX_COLS(MAX_C)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// shadow of the grid state and registers
	logic [LABEL_W-1:0] lbl_mem [CELLS];
	logic               up_mem  [CELLS];
	logic               rt_mem  [CELLS];
	logic [SIZE_W-1:0]  grid_rows_raw;
	logic [SIZE_W-1:0]  grid_cols_raw;

	grid_req_t  pending_q[$];
	grid_resp_t answer_q[$];
	int         queued_cnt = 0;
	int         taken_cnt = 0;
	int         fault_cnt = 0;
	int         stall_cnt = 0;
	logic       in_taken = 1'b0;
	logic       quiet = 1'b0;

	function automatic int clamp_size(logic [SIZE_W-1:0] raw, int limit);
		int v;
		v = (raw < 4) ? 20 : int'(raw);
		return (v > limit) ? limit : v;
	endfunction

	function automatic grid_resp_t apply_request(grid_req_t q);
		grid_resp_t a;
		int rows, cols, idx, nb;
		logic [LABEL_W-1:0] old_l, new_l;
		rows = clamp_size(grid_rows_raw, MAX_R);
		cols = clamp_size(grid_cols_raw, MAX_C);
		a = '0;
		if (int'(q.row) >= rows || int'(q.col) >= cols) begin
			a.status = STATUS_BORDER;
			return a;
		end
		idx = int'(q.row) * MAX_C + int'(q.col);
		if (q.req == REQ_READ) begin
			a.status = STATUS_READ;
		end else if ((q.dir == DIR_UP && q.row == 0) ||
				(q.dir == DIR_RIGHT && int'(q.col) + 1 >= cols)) begin
			a.status = STATUS_BORDER;
		end else begin
			nb = (q.dir == DIR_UP) ? idx - MAX_C : idx + 1;
			old_l = lbl_mem[idx];
			new_l = lbl_mem[nb];
			if (old_l == new_l) begin
				a.status = STATUS_SAME;
			end else begin
				if (q.dir == DIR_UP)
					up_mem[idx] = 1'b1;
				else
					rt_mem[idx] = 1'b1;
				// relabel only the cells in use
				for (int r = 0; r < rows; r++)
					for (int c = 0; c < cols; c++)
						if (lbl_mem[r * MAX_C + c] == old_l)
							lbl_mem[r * MAX_C + c] = new_l;
				a.status = STATUS_CARVED;
			end
		end
		a.up    = up_mem[idx];
		a.right = rt_mem[idx];
		a.label = lbl_mem[idx];
		return a;
	endfunction

	// input driver: advance on an accepted beat, idle now and then
	always @(negedge clk) begin : drive_in
		grid_req_t nxt;
		if (!s_tvalid || in_taken) begin
			if (pending_q.size() > 0 && !(!quiet && $urandom_range(0, 99) < 9)) begin
				nxt = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {5'b0, nxt.dir, nxt.col, nxt.row};
				s_tuser  <= nxt.req;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		m_tready <= !(!quiet && $urandom_range(0, 99) < 9);

	// monitor: predict on input beats, check output beats, watch for hangs
	always @(posedge clk) begin : watch
		grid_req_t  q;
		grid_resp_t got, want;
		logic       moved;
		moved = 1'b0;
		in_taken <= s_tvalid && s_tready;
		if (cfg_valid && cfg_ready) begin
			moved = 1'b1;
			if (cfg_index == REG_ROWS)
				grid_rows_raw = cfg_data;
			else
				grid_cols_raw = cfg_data;
		end
		if (s_tvalid && s_tready) begin
			moved = 1'b1;
			q.req = s_tuser;
			q.row = s_tdata[4:0];
			q.col = s_tdata[9:5];
			q.dir = s_tdata[10];
			answer_q.push_back(apply_request(q));
			taken_cnt++;
		end
		if (m_tvalid && m_tready) begin
			moved = 1'b1;
			got.status = m_tuser;
			got.up     = m_tdata[0];
			got.right  = m_tdata[1];
			got.label  = m_tdata[11:2];
			if (answer_q.size() == 0) begin
				$error("result beat with nothing expected");
				fault_cnt++;
			end else begin
				want = answer_q.pop_front();
				if (got.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fault_cnt++;
				end
				if (got.up != want.up) begin
					$error("up_open: expected %0d, got %0d", want.up, got.up);
					fault_cnt++;
				end
				if (got.right != want.right) begin
					$error("right_open: expected %0d, got %0d", want.right, got.right);
					fault_cnt++;
				end
				if (got.label != want.label) begin
					$error("set_label: expected %0d, got %0d", want.label, got.label);
					fault_cnt++;
				end
			end
		end
		stall_cnt = moved ? 0 : stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_req(logic req, int row, int col, logic dir);
		grid_req_t q;
		q.req = req;
		q.row = row[COORD_W-1:0];
		q.col = col[COORD_W-1:0];
		q.dir = dir;
		pending_q.push_back(q);
		queued_cnt++;
	endtask

	task automatic wait_idle();
		while (taken_cnt != queued_cnt || answer_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_size(logic idx, logic [SIZE_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// random beat: mostly in-grid carves, some reads, some raw noise
	task automatic push_random(int rows, int cols);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			push_req(1'($urandom_range(0, 1)), $urandom_range(0, 31),
				$urandom_range(0, 31), 1'($urandom_range(0, 1)));
		else if (pick < 25)
			push_req(REQ_READ, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
				1'($urandom_range(0, 1)));
		else
			push_req(REQ_CARVE, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
				1'($urandom_range(0, 1)));
	endtask

	int ph_rows [N_PHASES] = '{4, 32, 3, 0, 5, 32, 4, 12};
	int ph_cols [N_PHASES] = '{4, 32, 63, 33, 7, 4, 32, 9};
	int ph_items[N_PHASES] = '{60, 40, 40, 40, 80, 60, 60, 120};

	initial begin
		grid_rows_raw = SIZE_DEFAULT;
		grid_cols_raw = SIZE_DEFAULT;
		for (int i = 0; i < CELLS; i++) begin
			lbl_mem[i] = i[LABEL_W-1:0];
			up_mem[i]  = 1'b0;
			rt_mem[i]  = 1'b0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed beats on the reset-default 20 x 20 grid
		push_req(REQ_READ,  0,  0,  DIR_UP);
		push_req(REQ_READ,  31, 31, DIR_RIGHT);
		push_req(REQ_CARVE, 20, 5,  DIR_UP);
		push_req(REQ_CARVE, 5,  20, DIR_RIGHT);
		push_req(REQ_CARVE, 0,  3,  DIR_UP);
		push_req(REQ_CARVE, 7,  19, DIR_RIGHT);
		push_req(REQ_CARVE, 1,  0,  DIR_UP);
		push_req(REQ_CARVE, 1,  0,  DIR_UP);
		push_req(REQ_CARVE, 0,  0,  DIR_RIGHT);
		push_req(REQ_CARVE, 1,  1,  DIR_UP);
		push_req(REQ_CARVE, 1,  0,  DIR_RIGHT);
		push_req(REQ_READ,  1,  0,  DIR_RIGHT);
		push_req(REQ_CARVE, 19, 19, DIR_UP);
		push_req(REQ_CARVE, 19, 18, DIR_RIGHT);
		push_req(REQ_READ,  19, 19, DIR_UP);
		push_req(REQ_CARVE, 10, 10, DIR_RIGHT);
		push_req(REQ_READ,  31, 0,  DIR_UP);
		push_req(REQ_READ,  0,  31, DIR_UP);
		push_req(REQ_CARVE, 3,  3,  DIR_UP);
		push_req(REQ_READ,  3,  3,  DIR_RIGHT);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			write_size(REG_ROWS, ph_rows[p][SIZE_W-1:0]);
			write_size(REG_COLS, ph_cols[p][SIZE_W-1:0]);
			@(negedge clk);
			cfg_valid = 1'b0;
			// one phase runs with no idling on either side
			quiet = (p == 4);
			for (int i = 0; i < ph_items[p]; i++)
				push_random(clamp_size(grid_rows_raw, MAX_R),
					clamp_size(grid_cols_raw, MAX_C));
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (fault_cnt == 0 && answer_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/gwc_pkg.sv
rtl/core/gwc_ram.sv
rtl/core/gwc_scan.sv
rtl/core/grid_wall_carve_set_merge.sv
rtl/core/gwc_chk.sv
test/tb.sv
